/* sv/acss_pkg.sv */
//------------------------------------------------------------------------------
// acss_pkg
// Shared types and constants of the accelerometer smoothing and sleep block.
//------------------------------------------------------------------------------
`default_nettype none

package acss_pkg;

	localparam int AXIS_W    = 13;          // raw sample
	localparam int OFS_W     = 10;          // offset register
	localparam int SMP_W     = 14;          // offset sample, running sum
	localparam int QUO_W     = SMP_W - 1;   // one stored quotient
	localparam int ELAPSED_W = 8;
	localparam int IDLE_W    = 14;
	localparam int TAP_W     = 2;
	localparam int REG_IDX_W = 3;

	localparam logic [IDLE_W-1:0] IDLE_MAX    = {IDLE_W{1'b1}};
	localparam logic [IDLE_W-1:0] TIMEOUT_RST = IDLE_W'(10000);

	typedef enum logic [REG_IDX_W-1:0] {
		REG_OFFSET_X   = 3'd0,
		REG_OFFSET_Y   = 3'd1,
		REG_OFFSET_Z   = 3'd2,
		REG_SLEEP_EN   = 3'd3,
		REG_TIMEOUT_MS = 3'd4
	} reg_idx_t;

	typedef enum logic [TAP_W-1:0] {
		TAP_NONE   = 2'd0,
		TAP_SINGLE = 2'd1,
		TAP_DOUBLE = 2'd2
	} tap_kind_t;

	// per-request control fields that ride along with the sample
	typedef struct packed {
		logic [ELAPSED_W-1:0] elapsed_ms;
		logic                 inactivity;
		logic                 activity;
		logic                 single_tap;
		logic                 double_tap;
	} item_ctl_t;

	typedef struct packed {
		logic              sleep_enable;
		logic [IDLE_W-1:0] timeout_ms;
	} tmr_cfg_t;

	typedef struct packed {
		logic      wake_event;
		logic      sleep_event;
		tap_kind_t tap;
		logic      asleep;
	} tmr_res_t;

	function automatic logic signed [SMP_W-1:0] ofs_add(
		input logic signed [AXIS_W-1:0] a,
		input logic signed [OFS_W-1:0]  ofs
	);
		logic signed [SMP_W-1:0] ae;
		logic signed [SMP_W-1:0] oe;
		ae = {{(SMP_W-AXIS_W){a[AXIS_W-1]}}, a};
		oe = {{(SMP_W-OFS_W){ofs[OFS_W-1]}}, ofs};
		return ae + oe;
	endfunction

	function automatic logic signed [SMP_W-1:0] quo_ext(input logic signed [QUO_W-1:0] q);
		return {q[QUO_W-1], q};
	endfunction

endpackage

`default_nettype wire

/* sv/accel_smoothing_sleep_controller.sv */
//------------------------------------------------------------------------------
// accel_smoothing_sleep_controller
// Moving-average accelerometer smoothing with an inactivity sleep timer.
//------------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one request per sensor sample:
//   three axes, elapsed milliseconds and the sensor's interrupt flags.
//   Output channel (out_valid/out_stall) returns exactly one result per
//   request, in order: smoothed axes, wake/sleep events, tap kind, asleep.
//   The APB port holds offsets, sleep enable and the timeout; write it only
//   while no request is in flight.
//   Pipeline: a request passes through s1, s2 and the output register before
//   out_valid rises. Throughput: one request per cycle while in_stall is low;
//   the window store is read at accept and written when the request leaves
//   s1, at a different slot, so consecutive requests never wait on each other.
//   Each slot of the window memory holds the quotient sample / WINDOW_LEN;
//   the running sum subtracts the quotient leaving the window and adds the
//   new one.
//   Reset: offsets 0, sleep enabled, timeout 10000 ms, window reads as all
//   zero (per-slot valid bits), sums and timer cleared. No clearing pass.
//   Receiver stall: the result waits in the output register; requests keep
//   entering until s1 and s2 are full (at most two more), then in_stall rises.
//------------------------------------------------------------------------------
`default_nettype none

module accel_smoothing_sleep_controller import acss_pkg::*; #(
	parameter int WINDOW_LEN = 8
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	// configuration
	input  wire logic                     psel,
	input  wire logic                     penable,
	input  wire logic                     pwrite,
	input  wire logic [4:0]               paddr,
	input  wire logic [31:0]              pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	// requests
	input  wire logic                     in_valid,
	output logic                          in_stall,
	input  wire logic signed [AXIS_W-1:0] accel_x,
	input  wire logic signed [AXIS_W-1:0] accel_y,
	input  wire logic signed [AXIS_W-1:0] accel_z,
	input  wire logic [ELAPSED_W-1:0]     elapsed_ms,
	input  wire logic                     inactivity_irq,
	input  wire logic                     activity_irq,
	input  wire logic                     single_tap_irq,
	input  wire logic                     double_tap_irq,
	// results
	output logic                          out_valid,
	input  wire logic                     out_stall,
	output logic signed [SMP_W-1:0]       smooth_x,
	output logic signed [SMP_W-1:0]       smooth_y,
	output logic signed [SMP_W-1:0]       smooth_z,
	output logic                          wake_event,
	output logic                          sleep_event,
	output logic [TAP_W-1:0]              tap_kind,
	output logic                          asleep
);

	localparam int SLOT_W = $clog2(WINDOW_LEN);
	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW_LEN - 1);
	localparam logic signed [SMP_W-1:0] SUM_MIN = -SMP_W'(4608);
	localparam logic signed [SMP_W-1:0] SUM_MAX = SMP_W'(4608);

	//--------------------------------------------------------------------------
	// configuration registers
	//--------------------------------------------------------------------------
	logic signed [OFS_W-1:0] ofs_x_q, ofs_y_q, ofs_z_q;
	logic                    sleep_en_q;
	logic [IDLE_W-1:0]       timeout_q;
	reg_idx_t                reg_idx;
	logic                    cfg_wr;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[4:2]);
	assign cfg_wr  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ofs_x_q    <= '0;
			ofs_y_q    <= '0;
			ofs_z_q    <= '0;
			sleep_en_q <= 1'b1;
			timeout_q  <= TIMEOUT_RST;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_OFFSET_X:   ofs_x_q    <= pwdata[OFS_W-1:0];
				REG_OFFSET_Y:   ofs_y_q    <= pwdata[OFS_W-1:0];
				REG_OFFSET_Z:   ofs_z_q    <= pwdata[OFS_W-1:0];
				REG_SLEEP_EN:   sleep_en_q <= pwdata[0];
				REG_TIMEOUT_MS: timeout_q  <= pwdata[IDLE_W-1:0];
				default: ;      // unmapped: ignored
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_OFFSET_X:   prdata = {{(32-OFS_W){ofs_x_q[OFS_W-1]}}, ofs_x_q};
			REG_OFFSET_Y:   prdata = {{(32-OFS_W){ofs_y_q[OFS_W-1]}}, ofs_y_q};
			REG_OFFSET_Z:   prdata = {{(32-OFS_W){ofs_z_q[OFS_W-1]}}, ofs_z_q};
			REG_SLEEP_EN:   prdata = {31'd0, sleep_en_q};
			REG_TIMEOUT_MS: prdata = {{(32-IDLE_W){1'b0}}, timeout_q};
			default:        prdata = '0;
		endcase
	end

	//--------------------------------------------------------------------------
	// flow control: s1 (divide, store write), s2 (sum, timer), output reg
	//--------------------------------------------------------------------------
	logic s1_v_q, s2_v_q, out_v_q;
	logic in_acc, s1_adv, s2_adv;
	logic out_ready, s2_ready, s1_ready;

	assign out_ready = !out_v_q || !out_stall;
	assign s2_ready  = !s2_v_q || out_ready;
	assign s1_ready  = !s1_v_q || s2_ready;
	assign in_stall  = !s1_ready;
	assign in_acc    = in_valid && s1_ready;
	assign s1_adv    = s1_v_q && s2_ready;
	assign s2_adv    = s2_v_q && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q  <= 1'b0;
			s2_v_q  <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (in_acc) begin
				s1_v_q <= 1'b1;
			end else if (s1_adv) begin
				s1_v_q <= 1'b0;
			end
			if (s1_adv) begin
				s2_v_q <= 1'b1;
			end else if (s2_adv) begin
				s2_v_q <= 1'b0;
			end
			if (s2_adv) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	//--------------------------------------------------------------------------
	// write pointer: selects the slot read at accept
	//--------------------------------------------------------------------------
	logic [SLOT_W-1:0] slot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
		end else if (in_acc) begin
			slot_q <= (slot_q == SLOT_LAST) ? '0 : slot_q + 1'b1;
		end
	end

	//--------------------------------------------------------------------------
	// stage 1: offset sample registered, old quotients arrive from the store
	//--------------------------------------------------------------------------
	logic signed [SMP_W-1:0] smp_x_s1, smp_y_s1, smp_z_s1;
	logic [SLOT_W-1:0]       slot_s1;
	item_ctl_t               ctl_s1;

	always_ff @(posedge clk) begin
		if (in_acc) begin
			smp_x_s1 <= ofs_add(accel_x, ofs_x_q);
			smp_y_s1 <= ofs_add(accel_y, ofs_y_q);
			smp_z_s1 <= ofs_add(accel_z, ofs_z_q);
			slot_s1  <= slot_q;
			ctl_s1   <= '{elapsed_ms: elapsed_ms, inactivity: inactivity_irq,
				activity: activity_irq, single_tap: single_tap_irq,
				double_tap: double_tap_irq};
		end
	end

	logic signed [QUO_W-1:0] q_x, q_y, q_z;
	logic [3*QUO_W-1:0]      old_s1;

	acss_qdiv #(.WINDOW_LEN(WINDOW_LEN)) u_div_x (.smp(smp_x_s1), .quo(q_x));
	acss_qdiv #(.WINDOW_LEN(WINDOW_LEN)) u_div_y (.smp(smp_y_s1), .quo(q_y));
	acss_qdiv #(.WINDOW_LEN(WINDOW_LEN)) u_div_z (.smp(smp_z_s1), .quo(q_z));

	acss_qmem #(.DEPTH(WINDOW_LEN), .DATA_W(3 * QUO_W)) u_qmem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (in_acc),
		.rd_addr (slot_q),
		.wr_en   (s1_adv),
		.wr_addr (slot_s1),
		.wr_data ({q_z, q_y, q_x}),
		.rd_data (old_s1)
	);

	//--------------------------------------------------------------------------
	// stage 2: running sums and timer
	//--------------------------------------------------------------------------
	logic signed [QUO_W-1:0] q_x_s2, q_y_s2, q_z_s2;
	logic signed [QUO_W-1:0] old_x_s2, old_y_s2, old_z_s2;
	item_ctl_t               ctl_s2;

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			q_x_s2   <= q_x;
			q_y_s2   <= q_y;
			q_z_s2   <= q_z;
			old_x_s2 <= old_s1[QUO_W-1:0];
			old_y_s2 <= old_s1[2*QUO_W-1:QUO_W];
			old_z_s2 <= old_s1[3*QUO_W-1:2*QUO_W];
			ctl_s2   <= ctl_s1;
		end
	end

	logic signed [SMP_W-1:0] sum_x_q, sum_y_q, sum_z_q;
	logic signed [SMP_W-1:0] sum_x_nx, sum_y_nx, sum_z_nx;

	assign sum_x_nx = sum_x_q - quo_ext(old_x_s2) + quo_ext(q_x_s2);
	assign sum_y_nx = sum_y_q - quo_ext(old_y_s2) + quo_ext(q_y_s2);
	assign sum_z_nx = sum_z_q - quo_ext(old_z_s2) + quo_ext(q_z_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_x_q <= '0;
			sum_y_q <= '0;
			sum_z_q <= '0;
		end else if (s2_adv) begin
			sum_x_q <= sum_x_nx;
			sum_y_q <= sum_y_nx;
			sum_z_q <= sum_z_nx;
		end
	end

	tmr_cfg_t tmr_cfg;
	tmr_res_t tmr_res;

	assign tmr_cfg = '{sleep_enable: sleep_en_q, timeout_ms: timeout_q};

	acss_timer u_timer (
		.clk    (clk),
		.arst_n (arst_n),
		.upd    (s2_adv),
		.ctl    (ctl_s2),
		.cfg    (tmr_cfg),
		.res    (tmr_res)
	);

	//--------------------------------------------------------------------------
	// output register
	//--------------------------------------------------------------------------
	logic signed [SMP_W-1:0] smooth_x_q, smooth_y_q, smooth_z_q;
	tmr_res_t                res_q;

	always_ff @(posedge clk) begin
		if (s2_adv) begin
			smooth_x_q <= sum_x_nx;
			smooth_y_q <= sum_y_nx;
			smooth_z_q <= sum_z_nx;
			res_q      <= tmr_res;
		end
	end

	assign out_valid   = out_v_q;
	assign smooth_x    = smooth_x_q;
	assign smooth_y    = smooth_y_q;
	assign smooth_z    = smooth_z_q;
	assign wake_event  = res_q.wake_event;
	assign sleep_event = res_q.sleep_event;
	assign tap_kind    = res_q.tap;
	assign asleep      = res_q.asleep;

	//--------------------------------------------------------------------------
	// checks
	//--------------------------------------------------------------------------
	a_sum_range: assert property (@(posedge clk) disable iff (!arst_n)
		(sum_x_q >= SUM_MIN) && (sum_x_q <= SUM_MAX) &&
		(sum_y_q >= SUM_MIN) && (sum_y_q <= SUM_MAX) &&
		(sum_z_q >= SUM_MIN) && (sum_z_q <= SUM_MAX))
		else $error("running sum left the window range");

	a_event_state: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q |-> ((!res_q.sleep_event || res_q.asleep) &&
			(!res_q.wake_event || !res_q.asleep) &&
			!(res_q.sleep_event && res_q.wake_event)))
		else $error("sleep/wake event disagrees with asleep");

endmodule

`default_nettype wire

/* sv/acss_qdiv.sv */
//------------------------------------------------------------------------------
// acss_qdiv
// Signed divide by the window length, truncating toward zero.
//------------------------------------------------------------------------------
`default_nettype none

module acss_qdiv import acss_pkg::*; #(
	parameter int WINDOW_LEN = 8
) (
	input  wire logic signed [SMP_W-1:0] smp,
	output logic signed [QUO_W-1:0]      quo
);

	// reciprocal exact for every magnitude below 2**MAG_W
	localparam int MAG_W  = SMP_W - 1;
	localparam int LOG_N  = $clog2(WINDOW_LEN);
	localparam int SHIFT  = MAG_W + LOG_N;
	localparam int RECIP  = ((1 << SHIFT) + WINDOW_LEN - 1) / WINDOW_LEN;
	localparam int RCP_W  = MAG_W + 2;
	localparam int PROD_W = MAG_W + RCP_W;

	logic                    neg;
	logic [SMP_W-1:0]        abs_full;
	logic [MAG_W-1:0]        mag;
	logic [PROD_W-1:0]       prod;
	logic [PROD_W-1:0]       prod_sh;
	logic [QUO_W-1:0]        qmag;

	always_comb begin
		neg      = smp[SMP_W-1];
		abs_full = neg ? (SMP_W'(0) - smp) : smp;
		mag      = abs_full[MAG_W-1:0];
		prod     = PROD_W'(mag) * PROD_W'(RCP_W'(RECIP));
		prod_sh  = prod >> SHIFT;
		qmag     = prod_sh[QUO_W-1:0];
		quo      = neg ? (QUO_W'(0) - qmag) : qmag;
	end

endmodule

`default_nettype wire

/* sv/acss_qmem.sv */
//------------------------------------------------------------------------------
// acss_qmem
// Window store of per-slot quotients; unwritten slots read as zero.
//------------------------------------------------------------------------------
`default_nettype none

module acss_qmem import acss_pkg::*; #(
	parameter int DEPTH  = 8,
	parameter int DATA_W = 3 * QUO_W
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [DATA_W-1:0]        wr_data,
	output logic [DATA_W-1:0]             rd_data
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0]  valid_q;
	logic [DATA_W-1:0] rdata_q;
	logic              rvld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rvld_q  <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rvld_q <= valid_q[rd_addr];
			end
		end
	end

	assign rd_data = rvld_q ? rdata_q : '0;

	// the pointer spacing keeps a read and a write from meeting on one slot
	a_no_same_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_en && wr_en) |-> (rd_addr != wr_addr))
		else $error("qmem: read and write on one slot in one cycle");

endmodule

`default_nettype wire

/* sv/acss_timer.sv */
//------------------------------------------------------------------------------
// acss_timer
// Inactivity timer, sleep/wake state and tap decode.
//------------------------------------------------------------------------------
`default_nettype none

module acss_timer import acss_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      upd,
	input  wire item_ctl_t ctl,
	input  wire tmr_cfg_t  cfg,
	output tmr_res_t       res
);

	logic              still_q;
	logic              sleeping_q;
	logic [IDLE_W-1:0] idle_q;

	logic              still_nx;
	logic              sleeping_nx;
	logic [IDLE_W-1:0] idle_nx;
	logic [IDLE_W:0]   idle_sum;

	always_comb begin
		still_nx        = still_q;
		sleeping_nx     = sleeping_q;
		idle_nx         = idle_q;
		idle_sum        = '0;
		res.wake_event  = 1'b0;
		res.sleep_event = 1'b0;

		if (ctl.inactivity) begin
			still_nx = 1'b1;
			idle_nx  = '0;
		end
		if (ctl.activity) begin
			res.wake_event = sleeping_q;
			still_nx       = 1'b0;
			sleeping_nx    = 1'b0;
		end

		if (ctl.double_tap) begin
			res.tap = TAP_DOUBLE;
		end else if (ctl.single_tap) begin
			res.tap = TAP_SINGLE;
		end else begin
			res.tap = TAP_NONE;
		end

		if (still_nx && !sleeping_nx && cfg.sleep_enable) begin
			idle_sum = {1'b0, idle_nx} + (IDLE_W+1)'(ctl.elapsed_ms);
			idle_nx  = idle_sum[IDLE_W] ? IDLE_MAX : idle_sum[IDLE_W-1:0];
			if (idle_nx > cfg.timeout_ms) begin
				sleeping_nx     = 1'b1;
				res.sleep_event = 1'b1;
			end
		end
		res.asleep = sleeping_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			still_q    <= 1'b0;
			sleeping_q <= 1'b0;
			idle_q     <= '0;
		end else if (upd) begin
			still_q    <= still_nx;
			sleeping_q <= sleeping_nx;
			idle_q     <= idle_nx;
		end
	end

	a_sleep_has_event: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(sleeping_q) |-> $past(upd && res.sleep_event))
		else $error("timer: went to sleep without a sleep event");

endmodule

`default_nettype wire
